FILE: rtl/mwsd_pkg.sv
// shared types and constants of the moving-window standard deviation block
package mwsd_pkg;

  // window length register width and reset value
  localparam int unsigned LEN_BITS = 7;
  localparam logic [LEN_BITS-1:0] LEN_RESET = 7'd20;

  // result width and saturation bound, 8 fraction bits
  localparam int unsigned DEV_BITS = 31;
  localparam logic [DEV_BITS-1:0] DEV_MAX = 31'h7fff_ffff;

  // variance is scaled by 2^16 before the divide so the root carries 8 fraction bits
  localparam int unsigned SCALE_BITS = 16;

  // bits handled per cycle by the digit-serial multiplier and the divider
  localparam int unsigned DIG_BITS = 4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic cfg_write;   // new window length, empty the window
    logic take;        // capture an input beat
    logic locate;      // pick ring slot, swap in the new sample
    logic old_square;  // square the sample leaving the window
    logic update;      // update sums, fill count and slot
    logic load_nsq;    // start n * sum of squares
    logic load_s2;     // save n * sumsq, start sum * sum
    logic mul_step;    // one multiplier digit
    logic diff;        // form the scaled variance, start the divider
    logic div_step;    // one divider digit
    logic sqrt_init;   // arm the root counter
    logic sqrt_step;   // one root bit
    logic emit;        // load the result register
  } mwsd_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic has_result;  // this sample fills the window
    logic mul_last;    // current multiplier digit is the last one
    logic cnt_zero;    // divider or root counter at its last step
  } mwsd_sts_t;

endpackage

FILE: rtl/mwsd_ctrl.sv
// controller state machine of the moving-window standard deviation block
module mwsd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  output mwsd_pkg::mwsd_cmd_t cmd_o,
  input  mwsd_pkg::mwsd_sts_t sts_i
);
  import mwsd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOCATE,
    ST_OLD_SQ,
    ST_UPDATE,
    ST_LOAD_NSQ,
    ST_MUL_NSQ,
    ST_LOAD_S2,
    ST_MUL_S2,
    ST_DIFF,
    ST_DIV,
    ST_SQRT,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        cmd_o.cfg_write = cfg_valid_i;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_LOCATE;
        end
      end
      ST_LOCATE: begin
        cmd_o.locate = 1'b1;
        state_d      = ST_OLD_SQ;
      end
      ST_OLD_SQ: begin
        cmd_o.old_square = 1'b1;
        state_d          = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = sts_i.has_result ? ST_LOAD_NSQ : ST_IDLE;
      end
      ST_LOAD_NSQ: begin
        cmd_o.load_nsq = 1'b1;
        state_d        = ST_MUL_NSQ;
      end
      ST_MUL_NSQ: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          state_d = ST_LOAD_S2;
        end
      end
      ST_LOAD_S2: begin
        cmd_o.load_s2 = 1'b1;
        state_d       = ST_MUL_S2;
      end
      ST_MUL_S2: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.cnt_zero) begin
          cmd_o.sqrt_init = 1'b1;
          state_d         = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.cnt_zero) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/mwsd_datapath.sv
// datapath: sample ring, running sums, multiplier, divider and square root
module mwsd_datapath #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mwsd_pkg::mwsd_cmd_t               cmd_i,
  output mwsd_pkg::mwsd_sts_t               sts_o,
  input  logic [mwsd_pkg::LEN_BITS-1:0]     window_length_i,
  input  logic [SAMPLE_BITS-1:0]            price_sample_i,
  input  logic                              series_start_i,
  output logic [mwsd_pkg::DEV_BITS-1:0]     deviation_o
);
  import mwsd_pkg::*;

  localparam int unsigned NW   = LEN_BITS;
  localparam int unsigned AW   = $clog2(WINDOW_MAX);
  localparam int unsigned CW   = (AW > NW) ? AW : NW;
  localparam int unsigned SUMW = SAMPLE_BITS + NW;
  localparam int unsigned SQW  = 2 * SAMPLE_BITS + NW;
  localparam int unsigned VW   = 2 * SAMPLE_BITS + 2 * NW;
  localparam int unsigned QW   = VW + SCALE_BITS;
  localparam int unsigned QD   = (QW + DIG_BITS - 1) / DIG_BITS;
  localparam int unsigned QWP  = QD * DIG_BITS;
  localparam int unsigned RW   = QWP / 2;
  localparam int unsigned SRW  = RW + 2;
  localparam int unsigned DVW  = 2 * NW;
  localparam int unsigned XW   = (RW > DEV_BITS) ? RW : DEV_BITS;
  localparam int unsigned CNTW = $clog2(RW);

  // window state
  logic [NW-1:0]          len_q;
  logic [AW-1:0]          slot_q;
  logic [NW-1:0]          fill_q;
  logic [SUMW-1:0]        sum_q;
  logic [SQW-1:0]         sq_q;
  logic                   full_q;
  logic                   res_q;

  // sample path
  logic [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] x_q;
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [2*SAMPLE_BITS-1:0] xsq_q;
  logic [2*SAMPLE_BITS-1:0] osq_q;

  // arithmetic
  logic [VW-1:0]          ma_q;
  logic [SUMW-1:0]        mb_q;
  logic [VW-1:0]          acc_q;
  logic [VW-1:0]          nsq_q;
  logic [QWP-1:0]         dq_q;
  logic [DVW:0]           drem_q;
  logic [DVW-1:0]         dsor_q;
  logic [RW-1:0]          root_q;
  logic [SRW-1:0]         srem_q;
  logic [CNTW-1:0]        cnt_q;
  logic [DEV_BITS-1:0]    dev_q;

  logic [NW-1:0]          n_eff;
  logic [AW-1:0]          slot_use;
  logic [AW-1:0]          slot_nx;
  logic [CW:0]            slot_inc;
  logic [VW+DIG_BITS-1:0] pp;
  logic [VW-1:0]          vdiff;
  logic [DVW:0]           div_rem;
  logic [QWP-1:0]         div_q;
  logic [SRW-1:0]         rem_s;
  logic [SRW-1:0]         trial;
  logic [XW-1:0]          root_x;
  logic [DEV_BITS-1:0]    dev_sat;

  // length zero acts as one, above the ring depth acts as the depth
  always_comb begin
    if (len_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(len_q) > WINDOW_MAX) begin
      n_eff = NW'(WINDOW_MAX);
    end else begin
      n_eff = len_q;
    end
  end

  assign slot_use = (CW'(slot_q) >= CW'(n_eff)) ? '0 : slot_q;
  assign slot_inc = (CW + 1)'(slot_q) + 1'b1;
  assign slot_nx  = (slot_inc >= (CW + 1)'(n_eff)) ? '0 : slot_inc[AW-1:0];

  assign pp    = ma_q * mb_q[DIG_BITS-1:0];
  assign vdiff = (nsq_q >= acc_q) ? (nsq_q - acc_q) : '0;

  // restoring divide, one quotient digit per cycle
  always_comb begin
    div_rem = drem_q;
    div_q   = dq_q;
    for (int i = 0; i < DIG_BITS; i++) begin
      div_rem = {div_rem[DVW-1:0], div_q[QWP-1]};
      div_q   = {div_q[QWP-2:0], 1'b0};
      if (div_rem >= {1'b0, dsor_q}) begin
        div_rem  = div_rem - {1'b0, dsor_q};
        div_q[0] = 1'b1;
      end
    end
  end

  // bit-serial root, two radicand bits per step
  assign rem_s = {srem_q[SRW-3:0], dq_q[QWP-1 -: 2]};
  assign trial = {root_q, 2'b01};

  assign root_x  = XW'(root_q);
  assign dev_sat = (root_x > XW'(DEV_MAX)) ? DEV_MAX : root_x[DEV_BITS-1:0];

  assign sts_o.has_result = res_q;
  assign sts_o.mul_last   = ((mb_q >> DIG_BITS) == '0);
  assign sts_o.cnt_zero   = (cnt_q == '0);
  assign deviation_o      = dev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LEN_RESET;
      slot_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      full_q <= 1'b0;
      res_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.cfg_write) begin
        len_q  <= window_length_i;
        slot_q <= '0;
        fill_q <= '0;
        sum_q  <= '0;
        sq_q   <= '0;
      end
      if (cmd_i.take && series_start_i) begin
        slot_q <= '0;
        fill_q <= '0;
        sum_q  <= '0;
        sq_q   <= '0;
      end
      if (cmd_i.locate) begin
        slot_q <= slot_use;
        full_q <= (fill_q >= n_eff);
        res_q  <= ((NW + 1)'(fill_q) + 1'b1 >= (NW + 1)'(n_eff));
      end
      if (cmd_i.update) begin
        sum_q  <= sum_q + SUMW'(x_q) - (full_q ? SUMW'(rd_q) : '0);
        sq_q   <= sq_q + SQW'(xsq_q) - (full_q ? SQW'(osq_q) : '0);
        fill_q <= full_q ? n_eff : fill_q + 1'b1;
        slot_q <= slot_nx;
      end
      if (cmd_i.diff) begin
        cnt_q <= CNTW'(QD - 1);
      end else if (cmd_i.sqrt_init) begin
        cnt_q <= CNTW'(RW - 1);
      end else if (cmd_i.div_step || cmd_i.sqrt_step) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // ring: read-first, one port each way
  always_ff @(posedge clk_i) begin
    if (cmd_i.locate) begin
      ring[slot_use] <= x_q;
      rd_q           <= ring[slot_use];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      x_q <= price_sample_i;
    end
    if (cmd_i.locate) begin
      xsq_q <= x_q * x_q;
    end
    if (cmd_i.old_square) begin
      osq_q <= full_q ? rd_q * rd_q : '0;
    end
    if (cmd_i.load_nsq) begin
      ma_q  <= VW'(sq_q);
      mb_q  <= SUMW'(n_eff);
      acc_q <= '0;
    end else if (cmd_i.load_s2) begin
      nsq_q <= acc_q;
      ma_q  <= VW'(sum_q);
      mb_q  <= sum_q;
      acc_q <= '0;
    end else if (cmd_i.mul_step) begin
      acc_q <= acc_q + pp[VW-1:0];
      ma_q  <= ma_q << DIG_BITS;
      mb_q  <= mb_q >> DIG_BITS;
    end
    if (cmd_i.diff) begin
      dq_q   <= QWP'({vdiff, {SCALE_BITS{1'b0}}});
      drem_q <= '0;
      dsor_q <= DVW'(n_eff) * DVW'(n_eff);
      root_q <= '0;
      srem_q <= '0;
    end else if (cmd_i.div_step) begin
      dq_q   <= div_q;
      drem_q <= div_rem;
    end else if (cmd_i.sqrt_step) begin
      dq_q <= dq_q << 2;
      if (rem_s >= trial) begin
        srem_q <= rem_s - trial;
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        srem_q <= rem_s;
        root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
    if (cmd_i.emit) begin
      dev_q <= dev_sat;
    end
  end

endmodule

FILE: rtl/moving_window_std_deviation.sv
// top level of the moving-window population standard deviation block
//
// Keeps the last window_length price samples in a ring memory along with a running
// sum and sum of squares. Once the window holds window_length samples, every new
// sample produces one deviation beat: floor(sqrt(floor(65536*(N*sumsq - sum^2)/N^2))),
// i.e. the population standard deviation with 8 fraction bits, saturated to 31 bits.
// Samples taken while the window is still filling produce no beat. A series_start of
// 1 empties the window before that sample is stored; any write of window_length also
// empties it (0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX). Items are
// handled one at a time. For a sample that yields a result, the multiplier ends early
// when N is below 16 or the window sum is small, and the result waits while an earlier
// result has not yet left the output register. The square root, one root bit per cycle,
// is the longest step; the restoring divider by N^2 adds 4 quotient bits per cycle and
// the digit-serial multiplier for N*sumsq and sum^2 takes 4 bits per cycle. The result
// sits in an output register, so a new sample is accepted while it waits. The ring
// memory needs no clearing pass after reset.
module moving_window_std_deviation #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [SAMPLE_BITS-1:0]        price_sample_i,
  input  logic                          series_start_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mwsd_pkg::DEV_BITS-1:0] deviation_o,
  // window length register write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mwsd_pkg::LEN_BITS-1:0] window_length_i
);
  import mwsd_pkg::*;

  mwsd_cmd_t cmd;
  mwsd_sts_t sts;

  // sequencer: accepts beats, steps the datapath, owns the result valid
  mwsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // ring, running sums and the multiply, divide and root units
  mwsd_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .window_length_i (window_length_i),
    .price_sample_i  (price_sample_i),
    .series_start_i  (series_start_i),
    .deviation_o     (deviation_o)
  );

endmodule
